// File: hw/rtl/wts_pkg.sv
// weekly time switch: shared types, codes and the minute-to-second conversion
// no dependencies; imported by every module of the block

package wts_pkg;

   // operation codes carried by an input beat
   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_MANUAL_ON  = 2'd1,
      OP_MANUAL_OFF = 2'd2,
      OP_RESUME     = 2'd3
   } opcode_type;

   // configuration register indexes, one word apart
   typedef enum logic [1:0] {
      REG_START_MINUTE = 2'd0,
      REG_END_MINUTE   = 2'd1,
      REG_DAY_MASK     = 2'd2,
      REG_AUTO_SYNC    = 2'd3
   } reg_index_type;

   localparam int MINUTE_W  = 11;
   localparam int SECOND_W  = 17;
   localparam int MASK_W    = 8;
   localparam int WEEKDAY_W = 3;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [MINUTE_W-1:0] MINUTES_PER_DAY = 11'd1440;
   localparam logic [MINUTE_W-1:0] LAST_HOUR_MIN   = 11'd1380;  // 23:00
   localparam logic [MINUTE_W-1:0] MINUTES_PER_HR  = 11'd60;

   typedef struct packed {
      opcode_type              opcode;
      logic [WEEKDAY_W-1:0]    weekday;
      logic [SECOND_W-1:0]     second_of_day;
   } req_type;

   typedef struct packed {
      logic active;
      logic start_event;
      logic end_event;
   } rsp_type;

   // settings as the evaluation sees them
   typedef struct packed {
      logic [SECOND_W-1:0] on_sec;
      logic [SECOND_W-1:0] off_sec;
      logic [MASK_W-1:0]   day_mask;
      logic                auto_sync;
   } cfg_type;

   // minute register to seconds; values past the day read as 23:(value mod 60)
   function automatic logic [SECOND_W-1:0] minute_to_sec(input logic [MINUTE_W-1:0] m);
      logic [9:0]          d;
      logic [14:0]         prod;
      logic [4:0]          q;
      logic [MINUTE_W-1:0] r;
      logic [MINUTE_W-1:0] mins;
      d    = 10'd0;
      prod = 15'd0;
      q    = 5'd0;
      r    = '0;
      if (m >= MINUTES_PER_DAY) begin
         // 1440 is a multiple of 60, so reduce first and then take mod 60
         d    = 10'(m - MINUTES_PER_DAY);
         // q = d*17/1024 is floor(d/60) or one less
         prod = {1'b0, d, 4'b0000} + {5'b00000, d};
         q    = prod[14:10];
         r    = {1'b0, d} - 11'({6'b0, q} * MINUTES_PER_HR);
         if (r >= MINUTES_PER_HR) begin
            r = r - MINUTES_PER_HR;
         end
         mins = LAST_HOUR_MIN + r;
      end else begin
         mins = m;
      end
      // times 60 as 64x - 4x
      return SECOND_W'({mins, 6'b000000}) - SECOND_W'({mins, 2'b00});
   endfunction

endpackage

// File: hw/rtl/wts_csr.sv
// weekly time switch: configuration registers behind the apb-style port
// depends on wts_pkg; keeps the window bounds pre-converted to seconds

module wts_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [wts_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wts_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [wts_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output wts_pkg::cfg_type            cfg
);
   import wts_pkg::*;

   logic [MINUTE_W-1:0] start_minute_ff;
   logic [MINUTE_W-1:0] end_minute_ff;
   logic [MASK_W-1:0]   day_mask_ff;
   logic                auto_sync_ff;
   logic [SECOND_W-1:0] on_sec_ff;
   logic [SECOND_W-1:0] off_sec_ff;
   logic                wr_en;
   reg_index_type       reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);

   // register writes; the second form of each bound is kept alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         start_minute_ff <= '0;
         end_minute_ff   <= '0;
         day_mask_ff     <= '0;
         auto_sync_ff    <= 1'b0;
         on_sec_ff       <= '0;
         off_sec_ff      <= '0;
      end else if (wr_en) begin
         case (reg_sel)
            REG_START_MINUTE: begin
               start_minute_ff <= csr_pwdata[MINUTE_W-1:0];
               on_sec_ff       <= minute_to_sec(csr_pwdata[MINUTE_W-1:0]);
            end
            REG_END_MINUTE: begin
               end_minute_ff <= csr_pwdata[MINUTE_W-1:0];
               off_sec_ff    <= minute_to_sec(csr_pwdata[MINUTE_W-1:0]);
            end
            REG_DAY_MASK: begin
               day_mask_ff <= csr_pwdata[MASK_W-1:0];
            end
            REG_AUTO_SYNC: begin
               auto_sync_ff <= csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // read back
   always_comb begin
      case (reg_sel)
         REG_START_MINUTE: csr_prdata = CSR_DATA_W'(start_minute_ff);
         REG_END_MINUTE:   csr_prdata = CSR_DATA_W'(end_minute_ff);
         REG_DAY_MASK:     csr_prdata = CSR_DATA_W'(day_mask_ff);
         REG_AUTO_SYNC:    csr_prdata = CSR_DATA_W'(auto_sync_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.on_sec    = on_sec_ff;
   assign cfg.off_sec   = off_sec_ff;
   assign cfg.day_mask  = day_mask_ff;
   assign cfg.auto_sync = auto_sync_ff;

endmodule

// File: hw/rtl/wts_level.sv
// weekly time switch: level of the switch for a given weekday and time
// depends on wts_pkg; purely combinational

module wts_level (
   input  logic                            run,
   input  logic [wts_pkg::WEEKDAY_W-1:0]   weekday,
   input  logic [wts_pkg::SECOND_W-1:0]    now,
   input  wts_pkg::cfg_type                cfg,
   output logic                            level
);
   import wts_pkg::*;

   logic [MASK_W-1:0] today;
   logic [MASK_W-1:0] off_mask;
   logic              on_day;
   logic              off_day;
   logic              after_on;
   logic              before_off;
   logic              on_lt_off;
   logic              off_lt_on;

   // day bit, sunday on top and also on bit 0
   always_comb begin
      case (weekday)
         3'd1:    today = 8'b1000_0001;
         3'd2:    today = 8'b0100_0000;
         3'd3:    today = 8'b0010_0000;
         3'd4:    today = 8'b0001_0000;
         3'd5:    today = 8'b0000_1000;
         3'd6:    today = 8'b0000_0100;
         3'd7:    today = 8'b0000_0010;
         default: today = 8'b0000_0000;
      endcase
   end

   assign on_lt_off  = cfg.on_sec < cfg.off_sec;
   assign off_lt_on  = cfg.off_sec < cfg.on_sec;
   // window over midnight closes on the following day
   assign off_mask   = off_lt_on ? (cfg.day_mask >> 1) : cfg.day_mask;
   assign on_day     = |(today & cfg.day_mask);
   assign off_day    = |(today & off_mask);
   assign after_on   = now > cfg.on_sec;
   assign before_off = now < cfg.off_sec;

   // window decision
   always_comb begin
      if (!run) begin
         level = 1'b0;
      end else if (on_day && off_day) begin
         if (on_lt_off) begin
            level = after_on && before_off;
         end else if (off_lt_on) begin
            level = after_on || before_off;
         end else begin
            level = now == cfg.on_sec;
         end
      end else if (on_day) begin
         level = on_lt_off ? (after_on && before_off) : after_on;
      end else if (off_day) begin
         level = before_off;
      end else begin
         level = 1'b0;
      end
   end

endmodule

// File: hw/rtl/weekly_time_switch.sv
// weekly time switch: top level with input stage, switch state and result register
// depends on wts_pkg, wts_csr and wts_level
//
// Takes one beat per clock unless stalled and returns one result beat for each. A beat
// that is taken sits in the input register, where the window compare runs, and moves into
// the result register as the input stage advances; from there it is presented until taken.
// The enabled/level state is updated as a beat leaves the input register, so consecutive
// beats see each other's effect with no gap.
// A stalled result holds the result register and, when it holds a beat, the input stage.
// Configuration is to be written only while no beat is in flight; the block does not enforce it.

module weekly_time_switch (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  wts_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output wts_pkg::rsp_type               rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [wts_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wts_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [wts_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import wts_pkg::*;

   cfg_type cfg;
   logic    s1_valid_ff;
   req_type s1_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    enabled_ff;
   logic    enabled_in;
   logic    last_level_ff;
   logic    last_level_in;
   rsp_type rsp_data_in;
   logic    advance;
   logic    fire;
   logic    run;
   logic    level;

   wts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake: the input stage moves whenever the result register is free
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign fire      = s1_valid_ff && advance;

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_data;
      end
   end

   // resume runs the timer for its own evaluation
   assign run = (s1_data_ff.opcode == OP_RESUME) ? 1'b1 : enabled_ff;

   wts_level u_level (
      .run     (run),
      .weekday (s1_data_ff.weekday),
      .now     (s1_data_ff.second_of_day),
      .cfg     (cfg),
      .level   (level)
   );

   // next state and result for the beat in the input stage
   always_comb begin
      enabled_in              = enabled_ff;
      last_level_in           = last_level_ff;
      rsp_data_in.start_event = 1'b0;
      rsp_data_in.end_event   = 1'b0;
      case (s1_data_ff.opcode)
         OP_TICK: begin
            last_level_in           = level;
            rsp_data_in.start_event = level && !last_level_ff;
            rsp_data_in.end_event   = !level && last_level_ff;
         end
         OP_MANUAL_ON: begin
            enabled_in              = 1'b0;
            rsp_data_in.start_event = 1'b1;
         end
         OP_MANUAL_OFF: begin
            enabled_in            = 1'b0;
            rsp_data_in.end_event = 1'b1;
         end
         OP_RESUME: begin
            enabled_in              = 1'b1;
            last_level_in           = level;
            rsp_data_in.start_event = cfg.auto_sync && level;
            rsp_data_in.end_event   = cfg.auto_sync && !level;
         end
         default: begin
         end
      endcase
      rsp_data_in.active = last_level_in;
   end

   // switch state
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= 1'b1;
         last_level_ff <= 1'b0;
      end else if (fire) begin
         enabled_ff    <= enabled_in;
         last_level_ff <= last_level_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_events_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.start_event && rsp_data_ff.end_event))
      else $error("start and end event in the same result beat");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with an empty input stage");

   a_active_tracks_state: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_data_ff.active == last_level_ff))
      else $error("result level differs from stored level");

   a_manual_stops_timer: assert property (@(posedge clock) disable iff (reset)
      (fire && (s1_data_ff.opcode == OP_MANUAL_ON || s1_data_ff.opcode == OP_MANUAL_OFF))
      |=> !enabled_ff)
      else $error("manual beat left the timer running");

   a_manual_keeps_level: assert property (@(posedge clock) disable iff (reset)
      (fire && (s1_data_ff.opcode == OP_MANUAL_ON || s1_data_ff.opcode == OP_MANUAL_OFF))
      |=> $stable(last_level_ff))
      else $error("manual beat changed the stored level");

endmodule

// File: dv/testbench.sv
// self-checking testbench for weekly_time_switch: directed and random beats with a scoreboard
// depends on wts_pkg and the weekly_time_switch rtl; drives the csr port and both beat channels

module testbench;
   import wts_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SEGMENTS      = 12;
   localparam int SEGMENT_ITEMS = 120;

   // predicts the switch level and event pulses, and checks each result beat in order
   class switch_scoreboard;
      logic [MINUTE_W-1:0] start_minute;
      logic [MINUTE_W-1:0] end_minute;
      logic [MASK_W-1:0]   day_mask;
      logic                auto_sync;
      bit                  enabled;
      bit                  level;
      rsp_type             outputs_due[$];
      int                  mismatches;

      function new();
         start_minute = '0;
         end_minute   = '0;
         day_mask     = '0;
         auto_sync    = 1'b0;
         enabled      = 1'b1;
         level        = 1'b0;
         mismatches   = 0;
      endfunction

      function void set_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_START_MINUTE: start_minute = value[MINUTE_W-1:0];
            REG_END_MINUTE:   end_minute   = value[MINUTE_W-1:0];
            REG_DAY_MASK:     day_mask     = value[MASK_W-1:0];
            REG_AUTO_SYNC:    auto_sync    = value[0];
         endcase
      endfunction

      function logic [CSR_DATA_W-1:0] register_value(reg_index_type idx);
         case (idx)
            REG_START_MINUTE: return CSR_DATA_W'(start_minute);
            REG_END_MINUTE:   return CSR_DATA_W'(end_minute);
            REG_DAY_MASK:     return CSR_DATA_W'(day_mask);
            default:          return CSR_DATA_W'(auto_sync);
         endcase
      endfunction

      // minutes past the end of the day read as 23:(value mod 60)
      function int unsigned clamp_minute(logic [MINUTE_W-1:0] m);
         if (m > 1439) begin
            return 23 * 60 + (m % 60);
         end
         return m;
      endfunction

      function int unsigned minute_seconds(logic [MINUTE_W-1:0] m);
         return clamp_minute(m) * 60;
      endfunction

      function bit window_level(logic [WEEKDAY_W-1:0] wd, logic [SECOND_W-1:0] now);
         int unsigned    s;
         int unsigned    e;
         int unsigned    on_sec;
         int unsigned    off_sec;
         logic [MASK_W-1:0] today;
         logic [MASK_W-1:0] off_days;
         bit             on_day;
         bit             off_day;
         if (!enabled) begin
            return 1'b0;
         end
         s       = clamp_minute(start_minute);
         e       = clamp_minute(end_minute);
         on_sec  = s * 60;
         off_sec = e * 60;
         // sunday is the top bit and also sets bit 0; weekday zero has no bit
         today = (wd == 0) ? 8'h00 : (8'h80 >> (wd - 1));
         if (wd == 1) begin
            today[0] = 1'b1;
         end
         // a window across midnight closes on the following day
         off_days = (s > e) ? (day_mask >> 1) : day_mask;
         on_day   = (today & day_mask) != 0;
         off_day  = (today & off_days) != 0;
         if (on_day && off_day) begin
            if (on_sec < off_sec) begin
               return now > on_sec && now < off_sec;
            end
            if (off_sec < on_sec) begin
               return now > on_sec || now < off_sec;
            end
            return now == on_sec;
         end
         if (on_day) begin
            if (on_sec < off_sec) begin
               return now > on_sec && now < off_sec;
            end
            return now > on_sec;
         end
         if (off_day) begin
            return now < off_sec;
         end
         return 1'b0;
      endfunction

      function void note_request(req_type beat);
         rsp_type due;
         bit      lvl;
         due = '0;
         case (beat.opcode)
            OP_TICK: begin
               lvl             = window_level(beat.weekday, beat.second_of_day);
               due.start_event = lvl && !level;
               due.end_event   = !lvl && level;
               level           = lvl;
            end
            OP_MANUAL_ON: begin
               enabled         = 1'b0;
               due.start_event = 1'b1;
            end
            OP_MANUAL_OFF: begin
               enabled       = 1'b0;
               due.end_event = 1'b1;
            end
            default: begin
               enabled = 1'b1;
               lvl     = window_level(beat.weekday, beat.second_of_day);
               if (auto_sync) begin
                  due.start_event = lvl;
                  due.end_event   = !lvl;
               end
               level = lvl;
            end
         endcase
         due.active = level;
         outputs_due.push_back(due);
      endfunction

      function void check_response(rsp_type got);
         rsp_type due;
         if (outputs_due.size() == 0) begin
            $error("result beat with nothing expected: active %0d start_event %0d end_event %0d",
                   got.active, got.start_event, got.end_event);
            mismatches++;
            return;
         end
         due = outputs_due.pop_front();
         if (got.active !== due.active) begin
            $error("active: expected %0d, got %0d", due.active, got.active);
            mismatches++;
         end
         if (got.start_event !== due.start_event) begin
            $error("start_event: expected %0d, got %0d", due.start_event, got.start_event);
            mismatches++;
         end
         if (got.end_event !== due.end_event) begin
            $error("end_event: expected %0d, got %0d", due.end_event, got.end_event);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return outputs_due.size();
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   switch_scoreboard sb = new();
   int               idle_pct  = 0;
   int               stall_pct = 0;
   int               cycles    = 0;

   weekly_time_switch DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: check each accepted beat, then choose the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_data);
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // one beat, held until taken
   task automatic send_beat(input req_type beat);
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.note_request(beat);
   endtask

   task automatic idle_then_send(input req_type beat);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      send_beat(beat);
   endtask

   task automatic drive(input opcode_type op, input int unsigned wd, input int unsigned sec);
      req_type beat;
      beat.opcode        = op;
      beat.weekday       = wd[WEEKDAY_W-1:0];
      beat.second_of_day = sec[SECOND_W-1:0];
      send_beat(beat);
   endtask

   // hold off until every result is back and the pipeline is empty
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      sb.set_register(idx, value);
   endtask

   task automatic csr_read_check(input reg_index_type idx);
      logic [CSR_DATA_W-1:0] due;
      due = sb.register_value(idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      if (csr_prdata !== due) begin
         $error("%s: expected %0d, got %0d", idx.name(), due, csr_prdata);
         sb.mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_window(input int unsigned s, input int unsigned e,
                               input int unsigned m, input int unsigned a);
      csr_write(REG_START_MINUTE, s);
      csr_write(REG_END_MINUTE, e);
      csr_write(REG_DAY_MASK, m);
      csr_write(REG_AUTO_SYNC, a);
      csr_read_check(REG_START_MINUTE);
      csr_read_check(REG_END_MINUTE);
      csr_read_check(REG_DAY_MASK);
      csr_read_check(REG_AUTO_SYNC);
   endtask

   // settings per segment: fixed extremes first, then random ones
   task automatic program_window(input int seg);
      int unsigned s;
      int unsigned e;
      int unsigned m;
      int unsigned pick;
      case (seg)
         0: write_window(0, 1439, 8'hFF, 1);
         1: write_window(1439, 0, 8'h81, 0);
         2: write_window(2047, 2047, 8'h00, 1);
         3: write_window(1439, 1439, 8'hFE, 1);
         default: begin
            pick = $urandom_range(9);
            s    = (pick < 8) ? $urandom_range(1439) : $urandom_range(2047, 1440);
            pick = $urandom_range(9);
            if (pick < 2) begin
               e = s;
            end else if (pick < 9) begin
               e = $urandom_range(1439);
            end else begin
               e = $urandom_range(2047, 1440);
            end
            pick = $urandom_range(9);
            m    = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : $urandom_range(255);
            write_window(s, e, m, $urandom_range(1));
         end
      endcase
   endtask

   // mostly ticks, half of all beats timed near a window edge; the rest are manual and resume beats
   function automatic req_type random_request();
      req_type     beat;
      int unsigned pick;
      int unsigned edge_at;
      pick = $urandom_range(99);
      if (pick < 70) begin
         beat.opcode = OP_TICK;
      end else if (pick < 80) begin
         beat.opcode = OP_MANUAL_ON;
      end else if (pick < 90) begin
         beat.opcode = OP_MANUAL_OFF;
      end else begin
         beat.opcode = OP_RESUME;
      end
      beat.weekday = ($urandom_range(19) == 0) ? 3'd0 : WEEKDAY_W'($urandom_range(7, 1));
      pick = $urandom_range(9);
      if (pick < 4) begin
         beat.second_of_day = SECOND_W'($urandom_range(86399));
      end else if (pick == 4) begin
         beat.second_of_day = SECOND_W'($urandom_range(131071, 86400));
      end else begin
         edge_at = $urandom_range(1) ? sb.minute_seconds(sb.start_minute)
                                     : sb.minute_seconds(sb.end_minute);
         edge_at = edge_at + $urandom_range(4);
         beat.second_of_day = (edge_at < 2) ? '0 : SECOND_W'(edge_at - 2);
      end
      return beat;
   endfunction

   task automatic drive_directed_tail();
      // out-of-range minutes, window across midnight, sunday only, synced resume
      drain_and_settle();
      write_window(2047, 1500, 8'h01, 1);
      drive(OP_RESUME, 1, 83300);
      drive(OP_TICK, 2, 100);
      drive(OP_MANUAL_OFF, 4, 65536);
      drive(OP_RESUME, 1, 0);
      drive(OP_TICK, 1, 83220);
      // single-edge window
      drain_and_settle();
      write_window(0, 0, 8'hFE, 1);
      drive(OP_TICK, 4, 0);
      drive(OP_TICK, 4, 1);
      drive(OP_MANUAL_ON, 2, 65536);
      drive(OP_RESUME, 2, 0);
      drive(OP_TICK, 7, 0);

      // random segments: sender light and receiver heavy, then swapped, then no idling or stalls
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_and_settle();
         if (seg < 4) begin
            idle_pct  = 12;
            stall_pct = 67;
         end else if (seg < 8) begin
            idle_pct  = 67;
            stall_pct = 12;
         end else begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         program_window(seg);
         for (int i = 0; i < SEGMENT_ITEMS; i++) begin
            idle_then_send(random_request());
         end
      end

      drain_and_settle();
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   endtask

   // stimulus
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: daytime window every day, no sync on resume
      write_window(480, 1020, 8'hFF, 0);
      drive(OP_TICK, 1, 0);
      drive(OP_TICK, 1, 480 * 60);
      drive(OP_TICK, 1, 480 * 60 + 1);
      drive(OP_TICK, 0, 480 * 60 + 1);
      drive(OP_TICK, 7, 40000);
      drive(OP_MANUAL_ON, 7, 40000);
      drive(OP_TICK, 7, 40000);
      drive(OP_RESUME, 7, 40000);
      drive(OP_MANUAL_OFF, 3, 0);
      drive(OP_TICK, 3, 131071);
      drive(OP_RESUME, 5, 131071);
      drive(OP_TICK, 6, 86399);
      drive_directed_tail();
   end

endmodule

// File: filelist.f
hw/rtl/wts_pkg.sv
hw/rtl/wts_csr.sv
hw/rtl/wts_level.sv
hw/rtl/weekly_time_switch.sv
dv/testbench.sv
